>>> src/nfr_pkg.sv
// Shared types, command codes and the length table for the nibble frame receiver.
`default_nettype none

package nfr_pkg;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LOW  = 2'd1,
      PH_HIGH = 2'd2
   } phase_type;

   localparam logic EV_NIBBLE  = 1'b0;
   localparam logic EV_TIMEOUT = 1'b1;

   localparam logic ST_BYTE  = 1'b0;
   localparam logic ST_ABORT = 1'b1;

   // Commands, grouped by the number of data bytes that follow.
   localparam logic [7:0] CMD_NODATA_A = 8'h08;
   localparam logic [7:0] CMD_NODATA_B = 8'h0F;
   localparam logic [7:0] CMD_NODATA_C = 8'h6A;
   localparam logic [7:0] CMD_NODATA_D = 8'h71;
   localparam logic [7:0] CMD_LEN2_A   = 8'h73;
   localparam logic [7:0] CMD_LEN2_B   = 8'h79;
   localparam logic [7:0] CMD_LEN7     = 8'h7A;
   localparam logic [7:0] CMD_LEN8_A   = 8'h26;
   localparam logic [7:0] CMD_LEN8_B   = 8'h63;
   localparam logic [7:0] CMD_LEN8_C   = 8'h3E;
   localparam logic [7:0] CMD_LEN8_D   = 8'h39;

   localparam logic [3:0] LEN_NONE    = 4'd0;
   localparam logic [3:0] LEN_SHORT   = 4'd2;
   localparam logic [3:0] LEN_SEVEN   = 4'd7;
   localparam logic [3:0] LEN_EIGHT   = 4'd8;
   localparam logic [3:0] LEN_DEFAULT = 4'd9;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] held_nibble;
      logic [3:0] byte_count;
      logic [3:0] frame_length;
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       status;
      logic [7:0] byte_value;
      logic [3:0] byte_index;
      logic       last;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_HUNT,
      held_nibble:  4'd0,
      byte_count:   4'd0,
      frame_length: 4'd0
   };

   function automatic logic [3:0] length_for_command(input logic [7:0] cmd);
      logic [3:0] len;
      case (cmd) inside
         CMD_NODATA_A, CMD_NODATA_B, CMD_NODATA_C, CMD_NODATA_D: len = LEN_NONE;
         CMD_LEN2_A, CMD_LEN2_B:                                 len = LEN_SHORT;
         CMD_LEN7:                                               len = LEN_SEVEN;
         CMD_LEN8_A, CMD_LEN8_B, CMD_LEN8_C, CMD_LEN8_D:         len = LEN_EIGHT;
         default:                                                len = LEN_DEFAULT;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

>>> src/nibble_frame_receiver_unit.sv
// Top level of the nibble frame receiver: input register, frame state and result register.
//
//   channel | direction | handshake         | payload
//   req_    | in        | req_valid/stall   | event_kind, nibble_value
//   rsp_    | out       | rsp_valid/stall   | status, byte_value, byte_index, last
//
// One transaction per cycle while req_stall is low; results come from the result register.
// The input register is processed when the result register is empty or being drained.
// A result held by rsp_stall lets one more transaction wait in the input register.
// Synchronous reset returns the frame state to hunting and empties both registers.
`default_nettype none

module nibble_frame_receiver_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_event_kind,
   input  logic [3:0] req_nibble_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic [7:0] rsp_byte_value,
   output logic [3:0] rsp_byte_index,
   output logic       rsp_last
);
   import nfr_pkg::*;

   logic       in_valid_ff;
   logic       in_kind_ff;
   logic [3:0] in_nibble_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   result_type rsp_ff;
   result_type rsp_in;
   logic       out_free;
   logic       advance;

   assign out_free  = !rsp_ff.valid || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   nfr_frame_fsm u_fsm (
      .state_cur    (state_ff),
      .event_kind   (in_kind_ff),
      .nibble_value (in_nibble_ff),
      .state_nxt    (state_in),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff   <= req_event_kind;
         in_nibble_ff <= req_nibble_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // load the new result, or drop the one just taken
   always_comb begin
      rsp_in       = step_result;
      rsp_in.valid = advance && step_result.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else if (out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_ff.valid;
   assign rsp_status     = rsp_ff.status;
   assign rsp_byte_value = rsp_ff.byte_value;
   assign rsp_byte_index = rsp_ff.byte_index;
   assign rsp_last       = rsp_ff.last;

`ifndef SYNTH
   a_abort_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ABORT) |->
         (rsp_byte_value == 8'd0 && rsp_byte_index == 4'd0 && !rsp_last))
      else $error("abort result carries nonzero payload");

   a_last_hunts: assert property (@(posedge clock) disable iff (reset)
      (advance && step_result.valid && step_result.last) |=> (state_ff.phase == PH_HUNT))
      else $error("frame did not return to hunting after last byte");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.byte_count <= LEN_DEFAULT && state_ff.frame_length <= LEN_DEFAULT))
      else $error("byte count or frame length out of range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

>>> src/nfr_frame_fsm.sv
// Frame state machine: next state and result for one nibble or timeout event.
`default_nettype none

module nfr_frame_fsm (
   input  nfr_pkg::state_type  state_cur,
   input  logic                event_kind,
   input  logic [3:0]          nibble_value,
   output nfr_pkg::state_type  state_nxt,
   output nfr_pkg::result_type result
);
   import nfr_pkg::*;

   logic [7:0] byte_value;
   logic [3:0] cur_length;
   logic       is_last;

   assign byte_value = {nibble_value, state_cur.held_nibble};
   // The command byte sets the frame length in the same transaction.
   assign cur_length = (state_cur.byte_count == 4'd0) ? length_for_command(byte_value)
                                                      : state_cur.frame_length;
   assign is_last    = (state_cur.byte_count >= cur_length);

   // Next state
   always_comb begin
      state_nxt = state_cur;
      if (event_kind == EV_TIMEOUT) begin
         state_nxt = STATE_RESET;
      end else begin
         unique case (state_cur.phase)
            PH_LOW: begin
               state_nxt.held_nibble = nibble_value;
               state_nxt.phase       = PH_HIGH;
            end
            PH_HIGH: begin
               if (is_last) begin
                  state_nxt = STATE_RESET;
               end else begin
                  state_nxt.byte_count   = state_cur.byte_count + 4'd1;
                  state_nxt.frame_length = cur_length;
                  state_nxt.held_nibble  = 4'd0;
                  state_nxt.phase        = PH_LOW;
               end
            end
            default: begin
               // Hunting: skip zero nibbles, drop the header.
               state_nxt       = STATE_RESET;
               state_nxt.phase = (nibble_value != 4'd0) ? PH_LOW : PH_HUNT;
            end
         endcase
      end
   end

   // Outputs
   always_comb begin
      result = '0;
      if (event_kind == EV_TIMEOUT) begin
         result.valid  = 1'b1;
         result.status = ST_ABORT;
      end else begin
         unique case (state_cur.phase)
            PH_HIGH: begin
               result.valid      = 1'b1;
               result.status     = ST_BYTE;
               result.byte_value = byte_value;
               result.byte_index = state_cur.byte_count;
               result.last       = is_last;
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
